>>> rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared widths, register indexes and sideband types of the line clipper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbc_pkg;

  localparam int COORD_W  = 32;
  localparam int CODE_W   = 6;
  localparam int T_W      = 17;
  localparam int WIN_XY_W = 16;
  localparam int WIN_Z_W  = 32;
  localparam int FRAC_ONE = 65536;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SCALE_X  = 3'd0,
    CFG_SCALE_Y  = 3'd1,
    CFG_SCALE_Z  = 3'd2,
    CFG_OFFSET_X = 3'd3,
    CFG_OFFSET_Y = 3'd4,
    CFG_OFFSET_Z = 3'd5
  } cfg_idx_t;

  // carried alongside the plane dividers
  typedef struct packed {
    logic [3:0][COORD_W-1:0] a;
    logic [3:0][COORD_W-1:0] b;
    logic                    acc;
    logic                    clip;
    logic [5:0]              den_pos;
    logic [5:0]              den_neg;
    logic [5:0]              num_pos;
  } plane_side_t;

  // carried alongside the viewport dividers
  typedef struct packed {
    logic           vis;
    logic           clip;
    logic [T_W-1:0] te;
    logic [T_W-1:0] tl;
    logic [1:0]     wz;
  } view_side_t;

endpackage

>>> rtl/lbc_in_if.sv
// ----------------------------------------------------------------------------
// lbc_in_if
// Segment input channel: two clip-space endpoints and their outcodes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbc_in_if;
  import lbc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_start;
  logic signed [COORD_W-1:0] y_start;
  logic signed [COORD_W-1:0] z_start;
  logic signed [COORD_W-1:0] w_start;
  logic signed [COORD_W-1:0] x_end;
  logic signed [COORD_W-1:0] y_end;
  logic signed [COORD_W-1:0] z_end;
  logic signed [COORD_W-1:0] w_end;
  logic [CODE_W-1:0]         code_start;
  logic [CODE_W-1:0]         code_end;

  modport source (output valid, x_start, y_start, z_start, w_start,
                  x_end, y_end, z_end, w_end, code_start, code_end,
                  input ready);
  modport sink (input valid, x_start, y_start, z_start, w_start,
                x_end, y_end, z_end, w_end, code_start, code_end,
                output ready);
endinterface

>>> rtl/lbc_out_if.sv
// ----------------------------------------------------------------------------
// lbc_out_if
// Clipped segment result channel in window coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbc_out_if;
  import lbc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       visible;
  logic                       was_clipped;
  logic [T_W-1:0]             t_enter;
  logic [T_W-1:0]             t_leave;
  logic signed [WIN_XY_W-1:0] win_x_start;
  logic signed [WIN_XY_W-1:0] win_y_start;
  logic signed [WIN_Z_W-1:0]  win_z_start;
  logic signed [WIN_XY_W-1:0] win_x_end;
  logic signed [WIN_XY_W-1:0] win_y_end;
  logic signed [WIN_Z_W-1:0]  win_z_end;

  modport source (output valid, visible, was_clipped, t_enter, t_leave,
                  win_x_start, win_y_start, win_z_start,
                  win_x_end, win_y_end, win_z_end,
                  input ready);
  modport sink (input valid, visible, was_clipped, t_enter, t_leave,
                win_x_start, win_y_start, win_z_start,
                win_x_end, win_y_end, win_z_end,
                output ready);
endinterface

>>> rtl/homogeneous_line_clipper_core.sv
// ----------------------------------------------------------------------------
// homogeneous_line_clipper_core
// Homogeneous line clipper with viewport mapping, signed Q16.16.
// Pipeline: input register, 18-stage plane divider, interval, product, point
// and scale registers, 51-stage viewport divider, output register.
// Throughput: one segment per cycle; the whole pipe holds while a result waits.
// Reset: pipeline valid bits cleared, viewport scale 1.0 and offset 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module homogeneous_line_clipper_core (
  input  logic                   clk,
  input  logic                   rst_n,
  lbc_in_if.sink                 in_if,
  lbc_out_if.source              out_if,
  input  logic                   cfg_wr_en,
  input  logic [2:0]             cfg_index,
  input  logic [lbc_pkg::COORD_W-1:0] cfg_data
);
  import lbc_pkg::*;

  localparam int PQ = 17;   // plane quotient bits
  localparam int VQ = 50;   // viewport quotient bits

  logic en;

  // viewport registers
  logic signed [31:0] scale_r  [3];
  logic signed [31:0] offset_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        scale_r[k]  <= 32'sd65536;
        offset_r[k] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCALE_X:  scale_r[0]  <= cfg_data;
        CFG_SCALE_Y:  scale_r[1]  <= cfg_data;
        CFG_SCALE_Z:  scale_r[2]  <= cfg_data;
        CFG_OFFSET_X: offset_r[0] <= cfg_data;
        CFG_OFFSET_Y: offset_r[1] <= cfg_data;
        CFG_OFFSET_Z: offset_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being taken
  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  // ---- stage 1: plane numerators, denominators, outcode tests
  logic signed [31:0] ain [4];
  logic signed [31:0] bin [4];
  logic signed [32:0] din [4];
  logic signed [33:0] den_in [6];
  logic signed [33:0] num_in [6];

  always_comb begin
    ain[0] = in_if.x_start; ain[1] = in_if.y_start;
    ain[2] = in_if.z_start; ain[3] = in_if.w_start;
    bin[0] = in_if.x_end;   bin[1] = in_if.y_end;
    bin[2] = in_if.z_end;   bin[3] = in_if.w_end;
    for (int k = 0; k < 4; k++) begin
      din[k] = 33'(bin[k]) - 33'(ain[k]);
    end
    for (int k = 0; k < 3; k++) begin
      den_in[2*k]   = 34'(din[k]) + 34'(din[3]);
      num_in[2*k]   = -34'(ain[k]) - 34'(ain[3]);
      den_in[2*k+1] = 34'(din[3]) - 34'(din[k]);
      num_in[2*k+1] = 34'(ain[k]) - 34'(ain[3]);
    end
  end

  logic               v1_r;
  logic signed [33:0] den1_r [6];
  logic signed [33:0] num1_r [6];
  logic [31:0]        a1_r [4];
  logic [31:0]        b1_r [4];
  logic               acc1_r, clip1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_if.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        den1_r[j] <= den_in[j];
        num1_r[j] <= num_in[j];
      end
      for (int k = 0; k < 4; k++) begin
        a1_r[k] <= ain[k];
        b1_r[k] <= bin[k];
      end
      acc1_r  <= (in_if.code_start | in_if.code_end) == '0;
      clip1_r <= ((in_if.code_start | in_if.code_end) != '0) &&
                 ((in_if.code_start & in_if.code_end) == '0);
    end
  end

  // ---- plane dividers: t = num * 65536 / denom
  logic [5:0][48:0] pa_num;
  logic [5:0][33:0] pa_den;
  logic [5:0]       pa_neg;
  plane_side_t      pa_side, pb_side;
  logic [5:0][PQ:0] pb_quo;
  logic             pb_valid;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      logic [32:0] nm;
      nm = num1_r[j][33] ? 33'(-num1_r[j]) : 33'(num1_r[j]);
      pa_num[j] = {nm, 16'b0};
      pa_den[j] = den1_r[j][33] ? 34'(-den1_r[j]) : 34'(den1_r[j]);
      pa_neg[j] = num1_r[j][33] ^ den1_r[j][33];
      pa_side.den_pos[j] = !den1_r[j][33] && (den1_r[j] != '0);
      pa_side.den_neg[j] = den1_r[j][33];
      pa_side.num_pos[j] = !num1_r[j][33] && (num1_r[j] != '0);
    end
    for (int k = 0; k < 4; k++) begin
      pa_side.a[k] = a1_r[k];
      pa_side.b[k] = b1_r[k];
    end
    pa_side.acc  = acc1_r;
    pa_side.clip = clip1_r;
  end

  lbc_div #(
    .LANES (6), .NW (49), .DW (34), .QW (PQ), .SW ($bits(plane_side_t))
  ) u_plane_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .in_num    (pa_num),
    .in_den    (pa_den),
    .in_neg    (pa_neg),
    .in_side   (pa_side),
    .out_valid (pb_valid),
    .out_quo   (pb_quo),
    .out_side  (pb_side)
  );

  // ---- stage 2: narrow the interval plane by plane
  logic signed [PQ:0] te_c, tl_c;
  logic               ok_c;

  always_comb begin
    te_c = '0;
    tl_c = (PQ+1)'(FRAC_ONE);
    ok_c = 1'b1;
    for (int j = 0; j < 6; j++) begin
      if (ok_c) begin
        if (pb_side.den_pos[j]) begin
          if ($signed(pb_quo[j]) > tl_c) ok_c = 1'b0;
          else if ($signed(pb_quo[j]) > te_c) te_c = $signed(pb_quo[j]);
        end else if (pb_side.den_neg[j]) begin
          if ($signed(pb_quo[j]) < te_c) ok_c = 1'b0;
          else if ($signed(pb_quo[j]) < tl_c) tl_c = $signed(pb_quo[j]);
        end else if (pb_side.num_pos[j]) begin
          ok_c = 1'b0;
        end
      end
    end
  end

  logic               v2_r, vis2_r, clip2_r;
  logic [T_W-1:0]     te2_r, tl2_r;
  logic signed [31:0] a2_r [4];
  logic signed [32:0] d2_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= pb_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis2_r  <= pb_side.acc || (pb_side.clip && ok_c);
      clip2_r <= pb_side.clip;
      te2_r   <= pb_side.acc ? '0 : T_W'(te_c);
      tl2_r   <= pb_side.acc ? T_W'(FRAC_ONE) : T_W'(tl_c);
      for (int k = 0; k < 4; k++) begin
        a2_r[k] <= $signed(pb_side.a[k]);
        d2_r[k] <= 33'($signed(pb_side.b[k])) - 33'($signed(pb_side.a[k]));
      end
    end
  end

  // ---- stage 3: d * t for both endpoints
  logic               v3_r, vis3_r, clip3_r;
  logic [T_W-1:0]     te3_r, tl3_r;
  logic signed [31:0] a3_r [4];
  logic signed [50:0] ps3_r [4];
  logic signed [50:0] pe3_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis3_r  <= vis2_r;
      clip3_r <= clip2_r;
      te3_r   <= te2_r;
      tl3_r   <= tl2_r;
      for (int k = 0; k < 4; k++) begin
        a3_r[k]  <= a2_r[k];
        ps3_r[k] <= d2_r[k] * $signed({1'b0, te2_r});
        pe3_r[k] <= d2_r[k] * $signed({1'b0, tl2_r});
      end
    end
  end

  // ---- stage 4: interpolated points, floor of the Q16 product
  logic               v4_r, vis4_r, clip4_r;
  logic [T_W-1:0]     te4_r, tl4_r;
  logic signed [31:0] p4_r [2][4];

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis4_r  <= vis3_r;
      clip4_r <= clip3_r;
      te4_r   <= te3_r;
      tl4_r   <= tl3_r;
      for (int k = 0; k < 4; k++) begin
        p4_r[0][k] <= a3_r[k] + 32'(ps3_r[k] >>> 16);
        p4_r[1][k] <= a3_r[k] + 32'(pe3_r[k] >>> 16);
      end
    end
  end

  // ---- stage 5: point times viewport scale
  logic               v5_r;
  logic signed [63:0] vp5_r [6];
  logic signed [31:0] w5_r [2];
  view_side_t         side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int pt = 0; pt < 2; pt++) begin
        for (int ax = 0; ax < 3; ax++) begin
          vp5_r[pt*3+ax] <= p4_r[pt][ax] * scale_r[ax];
        end
        w5_r[pt]       <= p4_r[pt][3];
        side5_r.wz[pt] <= p4_r[pt][3] == '0;
      end
      side5_r.vis  <= vis4_r;
      side5_r.clip <= clip4_r;
      side5_r.te   <= te4_r;
      side5_r.tl   <= tl4_r;
    end
  end

  // ---- viewport dividers: (p * scale) / w
  logic [5:0][62:0] va_num;
  logic [5:0][31:0] va_den;
  logic [5:0]       va_neg;
  logic [5:0][VQ:0] vb_quo;
  logic             vb_valid;
  view_side_t       vb_side;

  always_comb begin
    for (int pt = 0; pt < 2; pt++) begin
      for (int ax = 0; ax < 3; ax++) begin
        va_num[pt*3+ax] = vp5_r[pt*3+ax][63] ? 63'(-vp5_r[pt*3+ax])
                                              : 63'(vp5_r[pt*3+ax]);
        va_den[pt*3+ax] = w5_r[pt][31] ? 32'(-w5_r[pt]) : 32'(w5_r[pt]);
        va_neg[pt*3+ax] = vp5_r[pt*3+ax][63] ^ w5_r[pt][31];
      end
    end
  end

  lbc_div #(
    .LANES (6), .NW (63), .DW (32), .QW (VQ), .SW ($bits(view_side_t))
  ) u_view_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_num    (va_num),
    .in_den    (va_den),
    .in_neg    (va_neg),
    .in_side   (side5_r),
    .out_valid (vb_valid),
    .out_quo   (vb_quo),
    .out_side  (vb_side)
  );

  // ---- final stage: offset, truncate toward zero, saturate
  logic signed [51:0] win_c [6];

  always_comb begin
    for (int pt = 0; pt < 2; pt++) begin
      for (int ax = 0; ax < 3; ax++) begin
        logic signed [51:0] vq;
        logic signed [51:0] sv;
        vq = vb_side.wz[pt] ? '0 : 52'($signed(vb_quo[pt*3+ax]));
        sv = vq + 52'(offset_r[ax]);
        win_c[pt*3+ax] = sv[51] ? ((sv + 52'sd65535) >>> 16) : (sv >>> 16);
      end
    end
  end

  function automatic logic [15:0] sat16(input logic signed [51:0] v);
    if (v > 52'sd32767) return 16'h7fff;
    else if (v < -52'sd32768) return 16'h8000;
    else return v[15:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) return 32'h7fffffff;
    else if (v < -52'sd2147483648) return 32'h80000000;
    else return v[31:0];
  endfunction

  // output register
  logic                       out_valid_r;
  logic                       vis_r, clip_r;
  logic [T_W-1:0]             te_r, tl_r;
  logic signed [WIN_XY_W-1:0] wxs_r, wys_r, wxe_r, wye_r;
  logic signed [WIN_Z_W-1:0]  wzs_r, wze_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vb_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r  <= vb_side.vis;
      clip_r <= vb_side.clip;
      te_r   <= vb_side.vis ? vb_side.te : '0;
      tl_r   <= vb_side.vis ? vb_side.tl : '0;
      wxs_r  <= vb_side.vis ? sat16(win_c[0]) : '0;
      wys_r  <= vb_side.vis ? sat16(win_c[1]) : '0;
      wzs_r  <= vb_side.vis ? sat32(win_c[2]) : '0;
      wxe_r  <= vb_side.vis ? sat16(win_c[3]) : '0;
      wye_r  <= vb_side.vis ? sat16(win_c[4]) : '0;
      wze_r  <= vb_side.vis ? sat32(win_c[5]) : '0;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.visible     = vis_r;
  assign out_if.was_clipped = clip_r;
  assign out_if.t_enter     = te_r;
  assign out_if.t_leave     = tl_r;
  assign out_if.win_x_start = wxs_r;
  assign out_if.win_y_start = wys_r;
  assign out_if.win_z_start = wzs_r;
  assign out_if.win_x_end   = wxe_r;
  assign out_if.win_y_end   = wye_r;
  assign out_if.win_z_end   = wze_r;

  // ---- checks
  // surviving interval is ordered
  a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.visible |-> out_if.t_enter <= out_if.t_leave)
    else $error("t_enter above t_leave");

  // rejected segments carry no coordinates
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.visible |->
      out_if.t_enter == '0 && out_if.t_leave == '0 &&
      out_if.win_x_start == '0 && out_if.win_y_start == '0 &&
      out_if.win_z_start == '0 && out_if.win_x_end == '0 &&
      out_if.win_y_end == '0 && out_if.win_z_end == '0)
    else $error("rejected segment with nonzero fields");

  // whole accept keeps the full interval
  a_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.visible && !out_if.was_clipped |->
      out_if.t_enter == '0 && out_if.t_leave == T_W'(FRAC_ONE))
    else $error("trivial accept with narrowed interval");

endmodule

>>> rtl/lbc_div.sv
// ----------------------------------------------------------------------------
// lbc_div
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Magnitudes in, signed saturated quotient out; QW+1 register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbc_div #(
  parameter int LANES = 1,
  parameter int NW    = 8,
  parameter int DW    = 8,
  parameter int QW    = 8,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   in_num,
  input  logic [LANES-1:0][DW-1:0]   in_den,
  input  logic [LANES-1:0]           in_neg,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [LANES-1:0][QW:0]     out_quo,
  output logic [SW-1:0]              out_side
);

  localparam int W = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [QW:0]       vld_r;
  logic [W-1:0]      rem_r   [QW+1][LANES];
  logic [QW-1:0]     quo_r   [QW+1][LANES];
  logic [DW-1:0]     den_r   [QW][LANES];
  logic [LANES-1:0]  sat_r   [QW+1];
  logic [LANES-1:0]  neg_r   [QW+1];
  logic [SW-1:0]     side_r  [QW+1];
  logic [W-1:0]      rem_nxt [QW][LANES];
  logic [QW-1:0]     quo_nxt [QW][LANES];

  // one trial subtract per stage and lane
  always_comb begin
    for (int s = 1; s <= QW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rem_nxt[s-1][l] = rem_r[s-1][l];
        quo_nxt[s-1][l] = quo_r[s-1][l];
        if (rem_r[s-1][l] >= (W'(den_r[s-1][l]) << (QW - s))) begin
          rem_nxt[s-1][l] = rem_r[s-1][l] - (W'(den_r[s-1][l]) << (QW - s));
          quo_nxt[s-1][l][QW-s] = 1'b1;
        end
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], in_valid};
    end
  end

  // payload stages; entry stage flags quotients that overflow QW bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l]  <= W'(in_num[l]);
        quo_r[0][l]  <= '0;
        den_r[0][l]  <= in_den[l];
        sat_r[0][l]  <= (W'(in_den[l]) << QW) <= W'(in_num[l]);
        neg_r[0][l]  <= in_neg[l];
      end
      side_r[0] <= in_side;
      for (int s = 1; s <= QW; s++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= rem_nxt[s-1][l];
          quo_r[s][l] <= quo_nxt[s-1][l];
        end
        sat_r[s]  <= sat_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        side_r[s] <= side_r[s-1];
      end
      for (int s = 1; s < QW; s++) begin
        for (int l = 0; l < LANES; l++) begin
          den_r[s][l] <= den_r[s-1][l];
        end
      end
    end
  end

  // saturate and apply sign
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [QW:0] mag;
      mag = sat_r[QW][l] ? {1'b0, {QW{1'b1}}} : {1'b0, quo_r[QW][l]};
      out_quo[l] = neg_r[QW][l] ? -mag : mag;
    end
  end

  assign out_valid = vld_r[QW];
  assign out_side  = side_r[QW];

endmodule

>>> tb/sv/lbc_tb_if.sv
// ----------------------------------------------------------------------------
// lbc_tb_if
// Testbench view of the channels; the RTL interfaces are reused as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block's own channel interfaces (lbc_in_if, lbc_out_if) carry the
// source and sink modports; this file holds the transfer record types
// shared by the stimulus and the checker.
package lbc_tb_pkg;
  import lbc_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] a [4];
    logic signed [COORD_W-1:0] b [4];
    logic [CODE_W-1:0]         c0;
    logic [CODE_W-1:0]         c1;
  } seg_t;

  typedef struct packed {
    logic                       visible;
    logic                       was_clipped;
    logic [T_W-1:0]             t_enter;
    logic [T_W-1:0]             t_leave;
    logic signed [WIN_XY_W-1:0] wxs;
    logic signed [WIN_XY_W-1:0] wys;
    logic signed [WIN_Z_W-1:0]  wzs;
    logic signed [WIN_XY_W-1:0] wxe;
    logic signed [WIN_XY_W-1:0] wye;
    logic signed [WIN_Z_W-1:0]  wze;
  } clip_res_t;
endpackage

>>> tb/sv/lbc_checker.sv
// ----------------------------------------------------------------------------
// lbc_checker
// Watches config writes and both channels, predicts each clipped segment and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbc_checker
  import lbc_pkg::*;
  import lbc_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  lbc_in_if                  in_if,
  lbc_out_if                 out_if,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  output int                 fail_cnt,
  output int                 pending
);

  longint    vp_scale [3];
  longint    vp_offset [3];
  clip_res_t clip_q [$];

  function automatic longint fl16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // one clip plane; returns 0 when the interval empties
  function automatic bit clip_plane(longint den, longint num, ref longint te, ref longint tl);
    longint t;
    if (den > 0) begin
      t = (num * FRAC_ONE) / den;
      if (t > tl) return 0;
      if (t > te) te = t;
    end else if (den < 0) begin
      t = (num * FRAC_ONE) / den;
      if (t < te) return 0;
      if (t < tl) tl = t;
    end else if (num > 0) begin
      return 0;
    end
    return 1;
  endfunction

  function automatic longint win_coord(longint p, longint w, int ax);
    longint v;
    v = 0;
    if (w != 0) v = (p * vp_scale[ax]) / w;
    v += vp_offset[ax];
    return v / FRAC_ONE;
  endfunction

  function automatic void map_pt(longint a[4], longint b[4], longint t,
                                 output longint wx, output longint wy,
                                 output longint wz);
    longint p [4];
    for (int k = 0; k < 4; k++) p[k] = a[k] + fl16((b[k] - a[k]) * t);
    wx = clampv(win_coord(p[0], p[3], 0), -32768, 32767);
    wy = clampv(win_coord(p[1], p[3], 1), -32768, 32767);
    wz = clampv(win_coord(p[2], p[3], 2), -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic clip_res_t clip_segment(seg_t s);
    clip_res_t r;
    longint a [4], b [4], d [4];
    longint te, tl, x0, y0, z0, x1, y1, z1;
    bit ok;
    r = '{default: 0};
    te = 0;
    tl = FRAC_ONE;
    for (int k = 0; k < 4; k++) begin
      a[k] = s.a[k];
      b[k] = s.b[k];
      d[k] = b[k] - a[k];
    end
    if ((s.c0 | s.c1) != 0) begin
      if ((s.c0 & s.c1) != 0) return r;
      r.was_clipped = 1;
      ok = clip_plane(d[0] + d[3], -a[0] - a[3], te, tl) &&
           clip_plane(-d[0] + d[3], a[0] - a[3], te, tl) &&
           clip_plane(d[1] + d[3], -a[1] - a[3], te, tl) &&
           clip_plane(-d[1] + d[3], a[1] - a[3], te, tl) &&
           clip_plane(d[2] + d[3], -a[2] - a[3], te, tl) &&
           clip_plane(-d[2] + d[3], a[2] - a[3], te, tl);
      if (!ok) return r;
    end
    r.visible = 1;
    r.t_enter = te[T_W-1:0];
    r.t_leave = tl[T_W-1:0];
    map_pt(a, b, te, x0, y0, z0);
    map_pt(a, b, tl, x1, y1, z1);
    r.wxs = x0[15:0]; r.wys = y0[15:0]; r.wzs = z0[31:0];
    r.wxe = x1[15:0]; r.wye = y1[15:0]; r.wze = z1[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    seg_t      s;
    clip_res_t e, g;
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        vp_scale[k] = FRAC_ONE;
        vp_offset[k] = 0;
      end
      fail_cnt = 0;
      clip_q.delete();
      pending = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SCALE_X, CFG_SCALE_Y, CFG_SCALE_Z:
            vp_scale[cfg_index] = longint'(signed'(cfg_data));
          CFG_OFFSET_X, CFG_OFFSET_Y, CFG_OFFSET_Z:
            vp_offset[cfg_index - CFG_OFFSET_X] = longint'(signed'(cfg_data));
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        s.a = '{in_if.x_start, in_if.y_start, in_if.z_start, in_if.w_start};
        s.b = '{in_if.x_end, in_if.y_end, in_if.z_end, in_if.w_end};
        s.c0 = in_if.code_start;
        s.c1 = in_if.code_end;
        clip_q.push_back(clip_segment(s));
      end
      if (out_if.valid && out_if.ready) begin
        g = '{out_if.visible, out_if.was_clipped, out_if.t_enter, out_if.t_leave,
              out_if.win_x_start, out_if.win_y_start, out_if.win_z_start,
              out_if.win_x_end, out_if.win_y_end, out_if.win_z_end};
        if (clip_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result, expected none, actual %p", $time, g);
        end else begin
          e = clip_q.pop_front();
          if (g !== e) begin
            fail_cnt++;
            $display("%0t: mismatch, expected %p, actual %p", $time, e, g);
          end
        end
      end
      pending = clip_q.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives segments and viewport settings into the line clipper under random
// idling on both channels; the checker scores every transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lbc_pkg::*;
  import lbc_tb_pkg::*;

  localparam int LATENCY   = 75;
  localparam int CYC_LIMIT = 400000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_wr_en = 0;
  logic [2:0]         cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;
  int                 fail_cnt, pending;
  int                 src_idle, snk_idle;
  int                 cycles = 0;

  lbc_in_if  in_ch ();
  lbc_out_if out_ch ();

  homogeneous_line_clipper_core i_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lbc_checker i_chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_cnt(fail_cnt), .pending(pending)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // one transfer; called at a falling edge, returns at a falling edge
  task automatic send_seg(seg_t s);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.x_start, in_ch.y_start, in_ch.z_start, in_ch.w_start} <=
      {s.a[0], s.a[1], s.a[2], s.a[3]};
    {in_ch.x_end, in_ch.y_end, in_ch.z_end, in_ch.w_end} <=
      {s.b[0], s.b[1], s.b[2], s.b[3]};
    in_ch.code_start <= s.c0;
    in_ch.code_end   <= s.c1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [CODE_W-1:0] outcode(logic signed [31:0] p[4]);
    longint w;
    w = p[3];
    return {p[2] > w, p[2] < -w, p[1] > w, p[1] < -w, p[0] > w, p[0] < -w};
  endfunction

  // random segment: mostly moderate coordinates with true outcodes
  function automatic seg_t rand_seg();
    seg_t s;
    int   mode;
    mode = $urandom_range(9);
    for (int k = 0; k < 4; k++) begin
      if (mode == 0) begin
        s.a[k] = $urandom;
        s.b[k] = $urandom;
      end else begin
        s.a[k] = $signed($urandom_range(8 * FRAC_ONE)) - 4 * FRAC_ONE;
        s.b[k] = $signed($urandom_range(8 * FRAC_ONE)) - 4 * FRAC_ONE;
      end
    end
    if (mode != 0) begin
      s.a[3] = $urandom_range(4 * FRAC_ONE);
      s.b[3] = $urandom_range(4 * FRAC_ONE);
    end
    if (mode <= 1) begin
      s.c0 = CODE_W'($urandom);
      s.c1 = CODE_W'($urandom);
    end else begin
      s.c0 = outcode(s.a);
      s.c1 = outcode(s.b);
    end
    return s;
  endfunction

  function automatic seg_t mk(int ax, int ay, int az, int aw, int bx, int by,
                              int bz, int bw, logic [5:0] c0, logic [5:0] c1);
    seg_t s;
    s.a = '{ax, ay, az, aw};
    s.b = '{bx, by, bz, bw};
    s.c0 = c0;
    s.c1 = c1;
    return s;
  endfunction

  localparam int ONE = FRAC_ONE;
  localparam int MX  = 32'h7fffffff;
  localparam int MN  = 32'h80000000;

  initial begin
    seg_t dir [$];
    int   n;
    src_idle = 0;
    snk_idle = 0;
    in_ch.valid = 0;
    {in_ch.x_start, in_ch.y_start, in_ch.z_start, in_ch.w_start} = '0;
    {in_ch.x_end, in_ch.y_end, in_ch.z_end, in_ch.w_end} = '0;
    in_ch.code_start = '0;
    in_ch.code_end = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: accept, reject, clip, clipped away, zero w, field extremes
    dir.push_back(mk(0, 0, 0, ONE, ONE/2, -ONE/2, ONE/4, ONE, 0, 0));
    dir.push_back(mk(MX, MX, MX, MX, MN, MN, MN, MN, 0, 0));
    dir.push_back(mk(MN, MN, MN, 1, MX, MX, MX, -1, 6'h3f, 6'h3f));
    dir.push_back(mk(2*ONE, 0, 0, ONE, 3*ONE, 0, 0, ONE, 6'h02, 6'h02));
    dir.push_back(mk(-2*ONE, 0, 0, ONE, 2*ONE, 0, 0, ONE, 6'h01, 6'h02));
    dir.push_back(mk(0, -3*ONE, 0, ONE, 0, 3*ONE, ONE/2, ONE, 6'h04, 6'h08));
    dir.push_back(mk(0, 0, -3*ONE, ONE, 0, 0, 3*ONE, ONE, 6'h10, 6'h20));
    dir.push_back(mk(2*ONE, 0, 0, ONE, 0, 3*ONE, 0, ONE, 6'h02, 6'h08));
    dir.push_back(mk(0, 0, 0, 0, ONE, ONE, ONE, 0, 6'h00, 6'h00));
    dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 6'h01, 6'h00));
    dir.push_back(mk(MX, MN, 0, MX, MN, MX, 0, MX, 6'h15, 6'h2a));
    dir.push_back(mk(-1, -1, -1, -1, 1, 1, 1, 1, 6'h3f, 6'h00));
    dir.push_back(mk(100*ONE, 0, 0, ONE, -100*ONE, 0, 0, ONE, 6'h02, 6'h01));
    @(negedge clk);
    foreach (dir[i]) send_seg(dir[i]);
    drain();

    // viewport extremes, then randoms under three idling regimes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_SCALE_X, 32'h7fffffff); write_reg(CFG_SCALE_Y, 32'h80000000);
          write_reg(CFG_SCALE_Z, 32'hffffffff); write_reg(CFG_OFFSET_X, 32'h7fffffff);
          write_reg(CFG_OFFSET_Y, 32'h80000000); write_reg(CFG_OFFSET_Z, 32'h0);
          src_idle = 20; snk_idle = 58;
        end
        1: begin
          write_reg(CFG_SCALE_X, 320 * ONE); write_reg(CFG_SCALE_Y, -240 * ONE);
          write_reg(CFG_SCALE_Z, 32'h7fffffff); write_reg(CFG_OFFSET_X, 320 * ONE);
          write_reg(CFG_OFFSET_Y, 240 * ONE); write_reg(CFG_OFFSET_Z, 32'h80000000);
          src_idle = 58; snk_idle = 20;
        end
        2: begin
          for (int r = 0; r < 6; r++) write_reg(cfg_idx_t'(r), $urandom);
          src_idle = 0; snk_idle = 0;
        end
        default: begin
          write_reg(CFG_SCALE_X, 32'h0); write_reg(CFG_SCALE_Y, ONE);
          write_reg(CFG_SCALE_Z, 32'h80000000); write_reg(CFG_OFFSET_X, -ONE);
          write_reg(CFG_OFFSET_Y, 32'h0); write_reg(CFG_OFFSET_Z, 32'h7fffffff);
        end
      endcase
      n = (ph == 3) ? 300 : 470;
      for (int i = 0; i < n; i++) begin
        // hold off once until the pipe has emptied
        if (ph == 0 && i == 200) begin
          in_ch.valid <= 0;
          do @(negedge clk); while (pending != 0);
        end
        send_seg(rand_seg());
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lbc_pkg.sv
rtl/lbc_in_if.sv
rtl/lbc_out_if.sv
rtl/lbc_div.sv
rtl/homogeneous_line_clipper_core.sv
tb/sv/lbc_tb_if.sv
tb/sv/lbc_checker.sv
tb/sv/tb_top.sv
